@@ design/i2c_master_byte_engine_unit_defines.svh @@
// Assertion macros used by the I2C master byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define I2CMBE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define I2CMBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/i2cmbe_pkg.sv @@
// Types, codes and constants of the I2C master byte engine.
package i2cmbe_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int PHASE_W = 4;
  localparam int BIT_W = 3;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [15:0] DELAY_TICKS_RESET = 16'd10;
  localparam logic [15:0] STRETCH_TIMEOUT_RESET = 16'd1000;
  localparam logic STRETCH_ENABLE_RESET = 1'b1;
  localparam logic [BIT_W-1:0] BIT_FIRST = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_START   = 3'd1,
    OP_RESTART = 3'd2,
    OP_STOP    = 3'd3,
    OP_WRITE   = 3'd4,
    OP_READ    = 3'd5,
    OP_ACK     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    REG_DELAY      = 2'd0,
    REG_TIMEOUT    = 2'd1,
    REG_STRETCH_EN = 2'd2
  } reg_idx_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NACK    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    WAIT_END  = 2'd0,
    WAIT_HALF = 2'd1,
    WAIT_FULL = 2'd2,
    WAIT_SCL  = 2'd3
  } wait_t;

  typedef struct packed {
    logic               sda_set;
    logic               sda_val;
    logic               scl_set;
    logic               scl_val;
    wait_t              wait_kind;
    logic [PHASE_W-1:0] wait_phase;
    logic               smp_ack;
    logic               smp_bit;
    logic               store;
    logic               bit_dec;
  } step_t;

endpackage

@@ design/i2cmbe_if.sv @@
// Request and result channel interfaces of the I2C master byte engine.
interface i2cmbe_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] write_data;
  logic       send_ack;
  logic       scl_sense;
  logic       sda_sense;

  modport source (output valid, operation, write_data, send_ack, scl_sense, sda_sense,
                  input ready);
  modport sink (input valid, operation, write_data, send_ack, scl_sense, sda_sense,
                output ready);
endinterface

interface i2cmbe_res_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic [1:0] status;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, read_data,
                  status, input ready);
  modport sink (input valid, scl_release, sda_release, busy_res, done_res, read_data,
                status, output ready);
endinterface

@@ design/i2cmbe_step.sv @@
// Sequence decode: pin actions and next wait for one entry point of an operation.
module i2cmbe_step import i2cmbe_pkg::*; (
  input  op_t                op,
  input  logic [PHASE_W-1:0] entry,
  input  logic [BIT_W-1:0]   bit_index,
  input  logic [7:0]         shift_byte,
  input  logic               send_ack,
  output step_t              step
);

  logic [BIT_W-1:0] bit_less;

  assign bit_less = bit_index - 1'b1;

  always_comb begin
    step = '0;
    step.wait_kind = WAIT_END;
    case (op)
      OP_START: begin
        case (entry)
          4'd0: begin
            step.sda_set = 1'b1; step.sda_val = 1'b0;
            step.wait_kind = WAIT_HALF; step.wait_phase = 4'd1;
          end
          4'd2: begin
            step.scl_set = 1'b1; step.scl_val = 1'b0;
          end
          default: ;
        endcase
      end
      OP_RESTART: begin
        case (entry)
          4'd0: begin
            step.sda_set = 1'b1; step.sda_val = 1'b1;
            step.scl_set = 1'b1; step.scl_val = 1'b1;
            step.wait_kind = WAIT_SCL; step.wait_phase = 4'd1;
          end
          4'd2: begin
            step.wait_kind = WAIT_HALF; step.wait_phase = 4'd2;
          end
          4'd3: begin
            step.sda_set = 1'b1; step.sda_val = 1'b0;
            step.wait_kind = WAIT_HALF; step.wait_phase = 4'd4;
          end
          4'd5: begin
            step.scl_set = 1'b1; step.scl_val = 1'b0;
          end
          default: ;
        endcase
      end
      OP_STOP: begin
        case (entry)
          4'd0: begin
            step.sda_set = 1'b1; step.sda_val = 1'b0;
            step.wait_kind = WAIT_HALF; step.wait_phase = 4'd1;
          end
          4'd2: begin
            step.scl_set = 1'b1; step.scl_val = 1'b1;
            step.wait_kind = WAIT_SCL; step.wait_phase = 4'd2;
          end
          4'd3: begin
            step.wait_kind = WAIT_HALF; step.wait_phase = 4'd3;
          end
          4'd4: begin
            step.sda_set = 1'b1; step.sda_val = 1'b1;
            step.wait_kind = WAIT_FULL; step.wait_phase = 4'd5;
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (entry)
          4'd0: begin
            step.scl_set = 1'b1; step.scl_val = 1'b0;
            step.sda_set = 1'b1; step.sda_val = shift_byte[bit_index];
            step.wait_kind = WAIT_HALF; step.wait_phase = 4'd2;
          end
          4'd3: begin
            step.scl_set = 1'b1; step.scl_val = 1'b1;
            step.wait_kind = WAIT_SCL; step.wait_phase = 4'd3;
          end
          4'd4: begin
            step.scl_set = 1'b1; step.scl_val = 1'b0;
            step.wait_kind = WAIT_HALF;
            if (bit_index != '0) begin
              step.bit_dec = 1'b1;
              step.sda_set = 1'b1; step.sda_val = shift_byte[bit_less];
              step.wait_phase = 4'd2;
            end else begin
              step.wait_phase = 4'd6;
            end
          end
          4'd7: begin
            step.sda_set = 1'b1; step.sda_val = 1'b1;
            step.wait_kind = WAIT_HALF; step.wait_phase = 4'd8;
          end
          4'd9: begin
            step.scl_set = 1'b1; step.scl_val = 1'b1;
            step.wait_kind = WAIT_SCL; step.wait_phase = 4'd9;
          end
          4'd10: begin
            step.smp_ack = 1'b1;
            step.scl_set = 1'b1; step.scl_val = 1'b0;
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (entry)
          4'd0: begin
            step.sda_set = 1'b1; step.sda_val = 1'b1;
            step.wait_kind = WAIT_HALF; step.wait_phase = 4'd1;
          end
          4'd2: begin
            step.scl_set = 1'b1; step.scl_val = 1'b1;
            step.wait_kind = WAIT_SCL; step.wait_phase = 4'd2;
          end
          4'd3: begin
            step.smp_bit = 1'b1;
            step.scl_set = 1'b1; step.scl_val = 1'b0;
            step.wait_kind = WAIT_FULL; step.wait_phase = 4'd5;
          end
          4'd6: begin
            if (bit_index != '0) begin
              step.bit_dec = 1'b1;
              step.scl_set = 1'b1; step.scl_val = 1'b1;
              step.wait_kind = WAIT_SCL; step.wait_phase = 4'd2;
            end else begin
              step.store = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_ACK: begin
        case (entry)
          4'd0: begin
            step.sda_set = 1'b1; step.sda_val = ~send_ack;
            step.wait_kind = WAIT_HALF; step.wait_phase = 4'd1;
          end
          4'd2: begin
            step.scl_set = 1'b1; step.scl_val = 1'b1;
            step.wait_kind = WAIT_SCL; step.wait_phase = 4'd2;
          end
          4'd3: begin
            step.scl_set = 1'b1; step.scl_val = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

@@ design/i2c_master_byte_engine_unit.sv @@
// Top level of the I2C master byte engine: sequencer state, APB registers, result register.
// Every request beat is one tick of the bus timebase carrying the sampled SCL and SDA levels;
// the engine takes one beat per clock cycle while res.ready is high or no result is pending,
// and registers its result (pin releases, busy, done, last read byte, status) in the output
// register, set by the single decode-and-update pass from the sequencer state. A start occupies
// 1 + half delay beats. Each written bit takes a half delay plus the SCL high time, and each
// read bit a full delay plus the SCL high time. Half delay is (delay_ticks+1)>>1 beats, and
// any wait lasts at least one beat. SCL high time is the beats until SCL reads high, or a
// half delay when stretch checking is off. Requests that arrive while an operation runs
// are ignored.
// Registers: delay_ticks at 0x0, stretch_timeout at 0x4, stretch_enable at 0x8;
// write them only while the engine is idle.
`include "i2c_master_byte_engine_unit_defines.svh"

module i2c_master_byte_engine_unit import i2cmbe_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  i2cmbe_req_if.sink            req,
  i2cmbe_res_if.source          res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [32:0] CountMax = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic [15:0] delay_ticks;
  logic [15:0] stretch_timeout;
  logic        stretch_enable;

  op_t                    current_op, op_next;
  logic [PHASE_W-1:0]     phase, phase_next;
  logic [COUNT_WIDTH-1:0] delay_count, delay_next;
  logic [COUNT_WIDTH-1:0] stretch_count, stretch_next;
  logic [7:0]             shift_byte, shift_next;
  logic [BIT_W-1:0]       bit_index, bit_next;
  logic                   scl_out, scl_next;
  logic                   sda_out, sda_next;
  logic [1:0]             last_status, status_next;
  logic [7:0]             read_reg, read_next;
  logic                   wait_on_scl, wait_next;
  logic                   done;

  logic                   res_valid;
  logic                   accept;
  logic                   idle;
  logic                   start_ok;
  logic                   run;
  op_t                    run_op;
  logic [PHASE_W-1:0]     entry;
  logic [BIT_W-1:0]       run_bit;
  logic [7:0]             run_shift;
  step_t                  step;
  logic [16:0]            half_sum;
  logic [COUNT_WIDTH-1:0] half_cap, full_cap, timeout_cap, stretch_inc;
  reg_idx_t               wr_idx;

  assign pready = 1'b1;
  assign wr_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks     <= DELAY_TICKS_RESET;
      stretch_timeout <= STRETCH_TIMEOUT_RESET;
      stretch_enable  <= STRETCH_ENABLE_RESET;
    end else if (psel && penable && pwrite) begin
      case (wr_idx)
        REG_DELAY:      delay_ticks <= pwdata[15:0];
        REG_TIMEOUT:    stretch_timeout <= pwdata[15:0];
        REG_STRETCH_EN: stretch_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_DELAY:      prdata = APB_DATA_W'(delay_ticks);
      REG_TIMEOUT:    prdata = APB_DATA_W'(stretch_timeout);
      REG_STRETCH_EN: prdata = APB_DATA_W'(stretch_enable);
      default:        prdata = '0;
    endcase
  end

  assign half_sum = 17'(delay_ticks) + 17'd1;
  assign half_cap = (33'(half_sum[16:1]) > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                                     : COUNT_WIDTH'(half_sum[16:1]);
  assign full_cap = (33'(delay_ticks) > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                                  : COUNT_WIDTH'(delay_ticks);
  assign timeout_cap = (33'(stretch_timeout) > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                                         : COUNT_WIDTH'(stretch_timeout);
  assign stretch_inc = (stretch_count != CountMax[COUNT_WIDTH-1:0])
                       ? stretch_count + 1'b1 : stretch_count;

  assign accept    = req.valid && req.ready;
  assign req.ready = !res_valid || res.ready;
  assign idle      = (current_op == OP_NONE);
  assign start_ok  = (req.operation >= OP_START) && (req.operation <= OP_ACK);
  assign run_op    = idle ? op_t'(req.operation) : current_op;
  assign entry     = idle ? '0 : phase + 1'b1;
  assign run_bit   = idle ? BIT_FIRST : bit_index;
  assign run_shift = idle ? ((req.operation == OP_WRITE) ? req.write_data : '0) : shift_byte;

  i2cmbe_step u_step (
    .op         (run_op),
    .entry      (entry),
    .bit_index  (run_bit),
    .shift_byte (run_shift),
    .send_ack   (req.send_ack),
    .step       (step)
  );

  always_comb begin
    op_next      = current_op;
    phase_next   = phase;
    delay_next   = delay_count;
    stretch_next = stretch_count;
    shift_next   = shift_byte;
    bit_next     = bit_index;
    scl_next     = scl_out;
    sda_next     = sda_out;
    status_next  = last_status;
    read_next    = read_reg;
    wait_next    = wait_on_scl;
    done         = 1'b0;
    run          = 1'b0;

    if (idle) begin
      if (start_ok) begin
        op_next     = run_op;
        phase_next  = '0;
        bit_next    = BIT_FIRST;
        shift_next  = run_shift;
        status_next = ST_OK;
        run         = 1'b1;
      end
    end else if (wait_on_scl) begin
      if (req.scl_sense) begin
        wait_next = 1'b0;
        run       = 1'b1;
      end else begin
        stretch_next = stretch_inc;
        if (stretch_inc >= timeout_cap) begin
          status_next = ST_TIMEOUT;
          op_next     = OP_NONE;
          phase_next  = '0;
          wait_next   = 1'b0;
          done        = 1'b1;
        end
      end
    end else begin
      if (delay_count > COUNT_WIDTH'(1)) begin
        delay_next = delay_count - 1'b1;
      end else begin
        delay_next = '0;
        run        = 1'b1;
      end
    end

    if (run) begin
      if (step.sda_set) sda_next = step.sda_val;
      if (step.scl_set) scl_next = step.scl_val;
      if (step.smp_ack) status_next = req.sda_sense ? ST_NACK : ST_OK;
      if (step.smp_bit && req.sda_sense) shift_next[run_bit] = 1'b1;
      if (step.store) read_next = run_shift;
      if (step.bit_dec) bit_next = run_bit - 1'b1;
      case (step.wait_kind)
        WAIT_HALF: begin
          wait_next  = 1'b0;
          delay_next = half_cap;
          phase_next = step.wait_phase;
        end
        WAIT_FULL: begin
          wait_next  = 1'b0;
          delay_next = full_cap;
          phase_next = step.wait_phase;
        end
        WAIT_SCL: begin
          phase_next = step.wait_phase;
          if (stretch_enable) begin
            wait_next    = 1'b1;
            stretch_next = '0;
          end else begin
            wait_next  = 1'b0;
            delay_next = half_cap;
          end
        end
        default: begin
          op_next    = OP_NONE;
          phase_next = '0;
          done       = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_op    <= OP_NONE;
      phase         <= '0;
      delay_count   <= '0;
      stretch_count <= '0;
      shift_byte    <= '0;
      bit_index     <= BIT_FIRST;
      scl_out       <= 1'b1;
      sda_out       <= 1'b1;
      last_status   <= ST_OK;
      read_reg      <= '0;
      wait_on_scl   <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        current_op    <= op_next;
        phase         <= phase_next;
        delay_count   <= delay_next;
        stretch_count <= stretch_next;
        shift_byte    <= shift_next;
        bit_index     <= bit_next;
        scl_out       <= scl_next;
        sda_out       <= sda_next;
        last_status   <= status_next;
        read_reg      <= read_next;
        wait_on_scl   <= wait_next;
        res_valid     <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.scl_release <= scl_next;
      res.sda_release <= sda_next;
      res.busy_res    <= (op_next != OP_NONE);
      res.done_res    <= done;
      res.read_data   <= read_next;
      res.status      <= status_next;
    end
  end

  assign res.valid = res_valid;

  `I2CMBE_ASSERT_SAME(a_done_not_busy, res_valid && res.done_res, !res.busy_res, "done with busy set")
  `I2CMBE_ASSERT_SAME(a_scl_wait_busy, wait_on_scl, current_op != OP_NONE, "SCL wait while idle")
  `I2CMBE_ASSERT_SAME(a_phase_busy, phase != '0, current_op != OP_NONE, "phase left while idle")
  `I2CMBE_ASSERT_NEXT(a_beat_result, accept, res_valid, "accepted beat gave no result")

endmodule
